[rtl/illm_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the indexed linked list manager
// no dependencies; used by illm_link_mem and indexed_linked_list_manager_unit
package illm_pkg;

    localparam int SLOTS = 64;
    localparam int IDX_W = $clog2(SLOTS);

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [31:0]        payload;
        logic signed [31:0] tag;
        logic [IDX_W-1:0]   position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] entry_count;
        logic [IDX_W-1:0] head_slot;
        logic [IDX_W-1:0] tail_slot;
    } out_item_t;

    // one write into a link table
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } link_wr_t;

    // power-up content of the next links: free chain 1 -> 2 -> ... -> last
    function automatic logic [IDX_W-1:0] next_init(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] val;
        if (idx == '0 || idx == IDX_W'(SLOTS - 1))
            val = '0;
        else
            val = idx + IDX_W'(1);
        return val;
    endfunction

endpackage

[rtl/illm_link_mem.sv]
`timescale 1ns / 1ps
// next and prev link tables: two synchronous rams with registered read
// entries never written read as their power-up value; depends on illm_pkg
module illm_link_mem
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [illm_pkg::IDX_W-1:0]   rd_addr,
    input  illm_pkg::link_wr_t           next_wr,
    input  illm_pkg::link_wr_t           prev_wr,
    output logic [illm_pkg::IDX_W-1:0]   next_rd,
    output logic [illm_pkg::IDX_W-1:0]   prev_rd
);

    logic [illm_pkg::IDX_W-1:0] next_mem [illm_pkg::SLOTS];
    logic [illm_pkg::IDX_W-1:0] prev_mem [illm_pkg::SLOTS];

    logic [illm_pkg::SLOTS-1:0] next_vld_reg;
    logic [illm_pkg::SLOTS-1:0] next_vld_next;
    logic [illm_pkg::SLOTS-1:0] prev_vld_reg;
    logic [illm_pkg::SLOTS-1:0] prev_vld_next;

    logic [illm_pkg::IDX_W-1:0] rd_addr_reg;
    logic                       next_hit_reg;
    logic                       prev_hit_reg;
    logic [illm_pkg::IDX_W-1:0] next_q_reg;
    logic [illm_pkg::IDX_W-1:0] prev_q_reg;

    always_ff @(posedge clk)
    begin
        if (next_wr.en)
        begin
            next_mem[next_wr.addr] <= next_wr.data;
        end
        if (prev_wr.en)
        begin
            prev_mem[prev_wr.addr] <= prev_wr.data;
        end
        if (rd_en)
        begin
            next_q_reg  <= next_mem[rd_addr];
            prev_q_reg  <= prev_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_comb
    begin
        next_vld_next = next_vld_reg;
        prev_vld_next = prev_vld_reg;
        if (next_wr.en)
        begin
            next_vld_next[next_wr.addr] = 1'b1;
        end
        if (prev_wr.en)
        begin
            prev_vld_next[prev_wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_vld_reg <= '0;
            prev_vld_reg <= '0;
            next_hit_reg <= 1'b0;
            prev_hit_reg <= 1'b0;
        end
        else
        begin
            next_vld_reg <= next_vld_next;
            prev_vld_reg <= prev_vld_next;
            if (rd_en)
            begin
                next_hit_reg <= next_vld_reg[rd_addr];
                prev_hit_reg <= prev_vld_reg[rd_addr];
            end
        end
    end

    // unwritten entries: next follows the power-up free chain, prev is null
    assign next_rd = next_hit_reg ? next_q_reg : illm_pkg::next_init(rd_addr_reg);
    assign prev_rd = prev_hit_reg ? prev_q_reg : '0;

endmodule

[rtl/indexed_linked_list_manager_unit.sv]
`timescale 1ns / 1ps
// indexed doubly linked list manager with a free list, top level
// depends on illm_pkg and illm_link_mem
//
// usage
// - command channel: drive cmd and raise start; the transfer happens at the
//   rising edge where start is high and busy is low. kind selects append at
//   tail (payload and tag stored in the next free slot) or remove of the slot
//   named by position.
// - result channel: done is high for exactly one cycle with result valid;
//   the transfer happens at the edge that ends that cycle. the receiver
//   cannot stall, so nothing is held back.
// - every command gives exactly one result: status, slot, entry count,
//   head and tail after the operation.
// - sequence: done is high in S_FIN, which follows S_EXEC after the command
//   transfer; busy stays high through S_EXEC and S_FIN. the order is set by
//   the link ram: the links of the slot are read at the transfer, then the
//   links are written in S_EXEC and again in S_FIN, because each link table
//   has a single write port.
// - reset: asynchronous, active low. the list is empty and all slots are
//   free right after reset; no clearing pass, the link ram keeps a written
//   bit per entry and unwritten entries read as their power-up links.
module indexed_linked_list_manager_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  illm_pkg::in_item_t   cmd,
    output logic                 done,
    output illm_pkg::out_item_t  result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // list bookkeeping
    logic [illm_pkg::IDX_W-1:0] free_head_reg;
    logic [illm_pkg::IDX_W-1:0] free_head_next;
    logic [illm_pkg::IDX_W-1:0] head_reg;
    logic [illm_pkg::IDX_W-1:0] head_next;
    logic [illm_pkg::IDX_W-1:0] tail_reg;
    logic [illm_pkg::IDX_W-1:0] tail_next;
    logic [illm_pkg::IDX_W-1:0] count_reg;
    logic [illm_pkg::IDX_W-1:0] count_next;
    logic [illm_pkg::SLOTS-1:0] in_use_reg;
    logic [illm_pkg::SLOTS-1:0] in_use_next;

    // operation in flight
    logic                       kind_reg;
    logic [1:0]                 status_reg;
    logic [illm_pkg::IDX_W-1:0] slot_reg;
    logic [illm_pkg::IDX_W-1:0] old_free_reg;

    // payload and tag store, written on append only
    logic [63:0] data_mem [illm_pkg::SLOTS];

    logic                       accept;
    logic                       is_append;
    logic [1:0]                 acc_status;
    logic [illm_pkg::IDX_W-1:0] acc_slot;
    logic                       op_ok;
    logic                       op_append;

    illm_pkg::link_wr_t         next_wr;
    illm_pkg::link_wr_t         prev_wr;
    logic [illm_pkg::IDX_W-1:0] nx_rd;
    logic [illm_pkg::IDX_W-1:0] pv_rd;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign is_append = (cmd.kind == illm_pkg::KIND_APPEND);

    // status is settled at the transfer from the free head and in-use bits
    always_comb
    begin
        if (is_append)
        begin
            acc_slot   = free_head_reg;
            acc_status = (free_head_reg == '0) ? illm_pkg::ST_FULL : illm_pkg::ST_OK;
        end
        else
        begin
            acc_slot = cmd.position;
            if (cmd.position == '0 || !in_use_reg[cmd.position])
                acc_status = illm_pkg::ST_BAD;
            else
                acc_status = illm_pkg::ST_OK;
        end
    end

    assign op_ok     = (status_reg == illm_pkg::ST_OK);
    assign op_append = (kind_reg == illm_pkg::KIND_APPEND);

    // links of the target slot are read at the command transfer
    illm_link_mem u_links
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (acc_slot),
        .next_wr (next_wr),
        .prev_wr (prev_wr),
        .next_rd (nx_rd),
        .prev_rd (pv_rd)
    );

    always_ff @(posedge clk)
    begin
        if (accept && is_append && free_head_reg != '0)
        begin
            data_mem[free_head_reg] <= {cmd.payload, cmd.tag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= cmd.kind;
            status_reg   <= acc_status;
            slot_reg     <= (acc_status == illm_pkg::ST_OK) ? acc_slot : '0;
            old_free_reg <= free_head_reg;
        end
    end

    // link writes: first pass patches the neighbors (and on append the slot's prev link), second pass the slot itself
    always_comb
    begin
        next_wr = '0;
        prev_wr = '0;
        case (state_reg)
            S_EXEC:
            begin
                if (op_append)
                begin
                    next_wr.en   = op_ok && (tail_reg != '0);
                    next_wr.addr = tail_reg;
                    next_wr.data = slot_reg;
                    prev_wr.en   = op_ok;
                    prev_wr.addr = slot_reg;
                    prev_wr.data = tail_reg;
                end
                else
                begin
                    next_wr.en   = op_ok && (pv_rd != '0);
                    next_wr.addr = pv_rd;
                    next_wr.data = nx_rd;
                    prev_wr.en   = op_ok && (nx_rd != '0);
                    prev_wr.addr = nx_rd;
                    prev_wr.data = pv_rd;
                end
            end
            S_FIN:
            begin
                // appended slot ends the list; removed slot joins the free list
                next_wr.en   = op_ok;
                next_wr.addr = slot_reg;
                next_wr.data = op_append ? '0 : old_free_reg;
                prev_wr.en   = op_ok && !op_append;
                prev_wr.addr = slot_reg;
                prev_wr.data = '0;
            end
            default:
            begin
                next_wr = '0;
                prev_wr = '0;
            end
        endcase
    end

    // bookkeeping moves in the first pass, off the registered pointers and the links read at the transfer
    always_comb
    begin
        free_head_next = free_head_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        in_use_next    = in_use_reg;
        if (state_reg == S_EXEC && op_ok)
        begin
            if (op_append)
            begin
                free_head_next        = nx_rd;
                tail_next             = slot_reg;
                if (count_reg == '0)
                    head_next = slot_reg;
                count_next            = count_reg + illm_pkg::IDX_W'(1);
                in_use_next[slot_reg] = 1'b1;
            end
            else
            begin
                if (head_reg == slot_reg)
                    head_next = nx_rd;
                if (tail_reg == slot_reg)
                    tail_next = pv_rd;
                if (count_reg != '0)
                    count_next = count_reg - illm_pkg::IDX_W'(1);
                in_use_next[slot_reg] = 1'b0;
                free_head_next        = slot_reg;
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= illm_pkg::IDX_W'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            in_use_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            in_use_reg    <= in_use_next;
        end
    end

    // result shows the state after the first pass
    assign done               = (state_reg == S_FIN);
    assign result.status      = status_reg;
    assign result.slot        = slot_reg;
    assign result.entry_count = count_reg;
    assign result.head_slot   = head_reg;
    assign result.tail_slot   = tail_reg;

    // a transfer always leads to exactly one result, shown in S_FIN after S_EXEC
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result not delivered two cycles after transfer");

    // no command is taken while a result is being shown
    a_no_accept_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("command taken during result cycle");

    // an empty list has neither head nor tail
    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with head or tail set");

    // failed commands report the null slot and leave the count alone
    a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !op_ok) |=> (slot_reg == '0 && $stable(count_reg)))
        else $error("failed command changed the list");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for indexed_linked_list_manager_unit: append and remove transfers
// are checked field by field against an in-bench list predictor; needs illm_pkg and the rtl
module tb_top;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    illm_pkg::in_item_t  cmd;
    logic                done;
    illm_pkg::out_item_t result;

    indexed_linked_list_manager_unit u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // predictor state: link tables, occupancy and list pointers
    // payload and tag never reach a result, so they are not tracked
    logic [illm_pkg::IDX_W-1:0] next_of [illm_pkg::SLOTS];
    logic [illm_pkg::IDX_W-1:0] prev_of [illm_pkg::SLOTS];
    logic                       linked  [illm_pkg::SLOTS];
    logic [illm_pkg::IDX_W-1:0] free_top;
    logic [illm_pkg::IDX_W-1:0] first_slot;
    logic [illm_pkg::IDX_W-1:0] last_slot;
    logic [illm_pkg::IDX_W-1:0] live_count;

    // list reports still owed by the unit, oldest first
    illm_pkg::out_item_t awaited_reports[$];

    int error_count;
    int sender_idle_pct;

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the unit hangs; far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // empty list, every slot on the free chain 1 -> 2 -> ... -> last
    function automatic void reset_list_model();
        for (int i = 0; i < illm_pkg::SLOTS; i++)
        begin
            next_of[i] = (i == 0 || i == illm_pkg::SLOTS - 1) ? '0 : illm_pkg::IDX_W'(i + 1);
            prev_of[i] = '0;
            linked[i]  = 1'b0;
        end
        free_top   = illm_pkg::IDX_W'(1);
        first_slot = '0;
        last_slot  = '0;
        live_count = '0;
    endfunction

    // apply one command to the predictor and return the report it should give
    function automatic illm_pkg::out_item_t apply_list_op(input illm_pkg::in_item_t c);
        illm_pkg::out_item_t        r;
        logic [illm_pkg::IDX_W-1:0] s;
        logic [illm_pkg::IDX_W-1:0] nx;
        logic [illm_pkg::IDX_W-1:0] pv;
        r.status = illm_pkg::ST_OK;
        r.slot   = '0;
        if (c.kind == illm_pkg::KIND_APPEND)
        begin
            s = free_top;
            // empty free chain: nothing changes
            if (s == '0)
                r.status = illm_pkg::ST_FULL;
            else
            begin
                free_top   = next_of[s];
                prev_of[s] = last_slot;
                // sentinel links are never written
                if (last_slot != '0)
                    next_of[last_slot] = s;
                next_of[s] = '0;
                linked[s]  = 1'b1;
                last_slot  = s;
                if (live_count == '0)
                    first_slot = s;
                live_count = live_count + illm_pkg::IDX_W'(1);
                r.slot     = s;
            end
        end
        else
        begin
            s = c.position;
            // sentinel or a slot sitting on the free chain
            if (s == '0 || !linked[s])
                r.status = illm_pkg::ST_BAD;
            else
            begin
                nx = next_of[s];
                pv = prev_of[s];
                if (pv != '0)
                    next_of[pv] = nx;
                if (nx != '0)
                    prev_of[nx] = pv;
                if (first_slot == s)
                    first_slot = nx;
                if (last_slot == s)
                    last_slot = pv;
                if (live_count != '0)
                    live_count = live_count - illm_pkg::IDX_W'(1);
                // freed slot goes on top of the free chain
                linked[s]  = 1'b0;
                prev_of[s] = '0;
                next_of[s] = free_top;
                free_top   = s;
                r.slot     = s;
            end
        end
        r.entry_count = live_count;
        r.head_slot   = first_slot;
        r.tail_slot   = last_slot;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // result side: done is a one-cycle strobe, the transfer is at the edge
    // that ends it; outputs are sampled before this edge's updates land
    always @(posedge clk)
    begin : check_results
        illm_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (awaited_reports.size() == 0)
                report_mismatch("result with none awaited, slot", int'(result.slot), 0);
            else
            begin
                want = awaited_reports.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", int'(result.status), int'(want.status));
                if (result.slot !== want.slot)
                    report_mismatch("slot", int'(result.slot), int'(want.slot));
                if (result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", int'(result.entry_count),
                                    int'(want.entry_count));
                if (result.head_slot !== want.head_slot)
                    report_mismatch("head_slot", int'(result.head_slot),
                                    int'(want.head_slot));
                if (result.tail_slot !== want.tail_slot)
                    report_mismatch("tail_slot", int'(result.tail_slot),
                                    int'(want.tail_slot));
            end
        end
    end

    // one command transfer; entered and left just after a rising edge.
    // start stays high into the next call unless an idle gap is drawn, so
    // it never sees two assignments in one step
    task automatic send_list_cmd(input illm_pkg::in_item_t c);
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // transfer happened at this edge
        awaited_reports.push_back(apply_list_op(c));
        if ($urandom_range(99) < sender_idle_pct)
        begin
            // idle gaps of random length so they land on every phase of the op
            start <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
    endtask

    function automatic illm_pkg::in_item_t append_cmd(input logic [31:0] p,
                                                      input logic signed [31:0] t);
        illm_pkg::in_item_t c;
        c.kind     = illm_pkg::KIND_APPEND;
        c.payload  = p;
        c.tag      = t;
        // position is ignored on append; keep it moving anyway
        c.position = illm_pkg::IDX_W'($urandom_range(illm_pkg::SLOTS - 1));
        return c;
    endfunction

    function automatic illm_pkg::in_item_t remove_cmd(input logic [illm_pkg::IDX_W-1:0] pos);
        illm_pkg::in_item_t c;
        c.kind     = illm_pkg::KIND_REMOVE;
        c.payload  = $urandom();
        c.tag      = $urandom();
        c.position = pos;
        return c;
    endfunction

    // a slot currently on the list, or any slot when the list is empty
    function automatic logic [illm_pkg::IDX_W-1:0] pick_linked_slot();
        logic [illm_pkg::IDX_W-1:0] pool[$];
        for (int i = 1; i < illm_pkg::SLOTS; i++)
            if (linked[i])
                pool.push_back(illm_pkg::IDX_W'(i));
        if (pool.size() == 0)
            return illm_pkg::IDX_W'($urandom_range(illm_pkg::SLOTS - 1));
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    // removes on an empty list: sentinel, last slot, first real slot
    task automatic test_empty_list_removes();
        send_list_cmd(remove_cmd('0));
        send_list_cmd(remove_cmd(illm_pkg::IDX_W'(illm_pkg::SLOTS - 1)));
        send_list_cmd(remove_cmd(illm_pkg::IDX_W'(1)));
    endtask

    // field extremes on append, then unlink middle, tail, head and the
    // only entry, a double remove, slot reuse and a sentinel remove
    task automatic test_link_and_unlink();
        send_list_cmd(append_cmd(32'h0000_0000, 32'sh8000_0000));
        send_list_cmd(append_cmd(32'hFFFF_FFFF, 32'sh7FFF_FFFF));
        send_list_cmd(append_cmd(32'hA5A5_5A5A, -32'sd1));
        send_list_cmd(append_cmd(32'h0000_0001, 32'sd0));
        send_list_cmd(remove_cmd(illm_pkg::IDX_W'(2)));
        send_list_cmd(remove_cmd(illm_pkg::IDX_W'(2)));
        send_list_cmd(remove_cmd(last_slot));
        send_list_cmd(remove_cmd(first_slot));
        send_list_cmd(remove_cmd(first_slot));
        send_list_cmd(append_cmd(32'h5A5A_A5A5, 32'sh0000_FFFF));
        send_list_cmd(remove_cmd('0));
        send_list_cmd(append_cmd(32'h8000_0000, 32'sh4000_0000));
    endtask

    // random commands, append share set by append_pct; removes mostly name live slots,
    // some head or tail, some arbitrary positions that may be free or the sentinel
    task automatic run_random_burst(input int n_items, input int append_pct);
        illm_pkg::in_item_t c;
        int                 r;
        repeat (n_items)
        begin
            c.kind    = ($urandom_range(99) < append_pct) ? illm_pkg::KIND_APPEND
                                                          : illm_pkg::KIND_REMOVE;
            c.payload = $urandom();
            c.tag     = $urandom();
            r         = $urandom_range(99);
            if (r < 75)
                c.position = pick_linked_slot();
            else if (r < 85)
                c.position = $urandom_range(1) ? first_slot : last_slot;
            else
                c.position = illm_pkg::IDX_W'($urandom_range(illm_pkg::SLOTS - 1));
            send_list_cmd(c);
        end
    endtask

    // fill past capacity, drain to empty, then mixed traffic
    task automatic test_random_traffic(input int idle_pct);
        sender_idle_pct = idle_pct;
        run_random_burst(96, 90);
        run_random_burst(96, 15);
        run_random_burst(96, 55);
        run_random_burst(96, 85);
        run_random_burst(86, 20);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = '0;
        error_count     = 0;
        sender_idle_pct = 0;
        reset_list_model();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list_removes();
        test_link_and_unlink();
        test_random_traffic(22);
        test_random_traffic(57);
        test_random_traffic(0);

        start <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        // idle on after the last report to catch a stray strobe
        repeat (6)
            @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
